// File: design/fpsw_pkg.sv
// shared constants and codes for the flash page state write-back unit
package fpsw_pkg;

	// default geometry
	localparam int PAGES_PER_BLOCK_DEF = 16;
	localparam int TOTAL_PAGES_DEF = 4096;

	// field widths
	localparam int CMD_W = 3;
	localparam int PAGE_W = 12;
	localparam int FLAG_W = 4;
	localparam int OP_W = 3;
	localparam int MEMP_W = 13;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 16;

	// reset value of the page count register
	localparam logic [MEMP_W-1:0] MEM_PAGES_RST = 13'd4096;

	// host commands
	localparam logic [CMD_W-1:0] CMD_READ = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_COMMIT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LOAD = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QUERY = 3'd4;

	// flash operations
	localparam logic [OP_W-1:0] OP_ACK = 3'd0;
	localparam logic [OP_W-1:0] OP_READ = 3'd1;
	localparam logic [OP_W-1:0] OP_ERASE = 3'd2;
	localparam logic [OP_W-1:0] OP_PROGRAM = 3'd3;
	localparam logic [OP_W-1:0] OP_RANGE = 3'd4;

	// page flag bits
	localparam int FL_READ = 0;
	localparam int FL_DIRTY = 1;
	localparam int FL_DATA = 2;
	localparam int FL_ERASE = 3;

endpackage

// File: design/flash_page_state_write_back_unit.sv
// top level: page flag table and sequencer turning host requests into flash operations
// requests are accepted only in idle, so each one is finished before the next is taken
// a commit walks its block up to three times, reading each page from the flag ram
// reset: arst_n clears control; the flag ram is then cleared one entry a cycle,
//   and no request is accepted until every entry is cleared
module flash_page_state_write_back_unit #(
	parameter int PAGES_PER_BLOCK = fpsw_pkg::PAGES_PER_BLOCK_DEF,
	parameter int TOTAL_PAGES = fpsw_pkg::TOTAL_PAGES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration: mem_pages
	input  logic                             cfg_we,
	input  logic [fpsw_pkg::MEMP_W-1:0]      cfg_wdata,
	// requests
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// page_index [11:0], partial [12], flag_value [16:13], zero [23:17]
	input  logic [fpsw_pkg::S_TDATA_W-1:0]   s_tdata,
	// command [2:0]
	input  logic [fpsw_pkg::CMD_W-1:0]       s_tuser,
	// results
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// flash_page [11:0], page_flags [15:12]
	output logic [fpsw_pkg::M_TDATA_W-1:0]   m_tdata,
	// operation [2:0]
	output logic [fpsw_pkg::OP_W-1:0]        m_tuser,
	output logic                             m_tlast
);

	import fpsw_pkg::*;

	localparam int AW = $clog2(TOTAL_PAGES);
	localparam int IW = $clog2(PAGES_PER_BLOCK + 1);
	localparam int RSH = 24;
	localparam logic [RSH:0] RECIP = (RSH+1)'(((1 << RSH) + PAGES_PER_BLOCK - 1) / PAGES_PER_BLOCK);

	typedef enum logic [9:0] {
		ST_CLEAR = 10'b0000000001,
		ST_IDLE  = 10'b0000000010,
		ST_DEC   = 10'b0000000100,
		ST_ACC   = 10'b0000001000,
		ST_ACK   = 10'b0000010000,
		ST_BLK   = 10'b0000100000,
		ST_RD    = 10'b0001000000,
		ST_EX    = 10'b0010000000,
		ST_ERA   = 10'b0100000000,
		ST_FIN   = 10'b1000000000
	} state_t;

	typedef enum logic [2:0] {
		PS_SCAN  = 3'b001,
		PS_FETCH = 3'b010,
		PS_PROG  = 3'b100
	} pass_t;

	state_t state_q;
	pass_t pass_q;

	logic [MEMP_W-1:0] mem_pages_q;
	logic [AW-1:0] clr_q;

	// request fields
	logic [CMD_W-1:0] cmd_q;
	logic [PAGE_W-1:0] page_q;
	logic partial_q;
	logic [FLAG_W-1:0] fval_q;

	// block walk
	logic [PAGE_W-1:0] quot_q;
	logic [MEMP_W-1:0] bsp_q;
	logic [IW-1:0] idx_q;
	logic any_dirty_q;
	logic any_erase_q;
	logic [IW-1:0] last_d_q;
	logic [IW-1:0] last_dd_q;
	logic [FLAG_W-1:0] pflags_q;

	// final acknowledge
	logic [PAGE_W-1:0] ack_page_q;
	logic [FLAG_W-1:0] ack_flags_q;

	// output register
	logic m_tvalid_q;
	logic [OP_W-1:0] op_q;
	logic [PAGE_W-1:0] fpage_q;
	logic [FLAG_W-1:0] oflags_q;
	logic olast_q;

	// ram ports
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [FLAG_W-1:0] ram_wdata;
	logic ram_re;
	logic [AW-1:0] ram_raddr;
	logic [FLAG_W-1:0] rf;

	// combinational helpers
	logic [MEMP_W-1:0] lim;
	logic [MEMP_W-1:0] p;
	logic p_end;
	logic bad_req;
	logic can_emit;
	logic go;
	logic emit;
	logic [OP_W-1:0] e_op;
	logic [PAGE_W-1:0] e_page;
	logic [FLAG_W-1:0] e_flags;
	logic e_last;
	logic [FLAG_W-1:0] acc_nf;
	logic acc_need;
	logic [PAGE_W+RSH:0] qprod;
	logic [PAGE_W+4:0] bsp_full;

	// page flag table
	fpsw_ram #(
		.WIDTH(FLAG_W),
		.DEPTH(TOTAL_PAGES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rf)
	);

	// page limit and block walk position
	assign lim = (int'(mem_pages_q) < TOTAL_PAGES) ? mem_pages_q : MEMP_W'(TOTAL_PAGES);
	assign p = bsp_q + MEMP_W'(idx_q);
	assign p_end = (idx_q == IW'(PAGES_PER_BLOCK)) || (p >= lim);
	assign bad_req = (cmd_q > CMD_QUERY) || ({1'b0, page_q} >= lim);
	assign can_emit = !m_tvalid_q || m_tready;

	// block start: quotient by reciprocal, then back to a page number
	assign qprod = (PAGE_W+RSH+1)'(page_q) * (PAGE_W+RSH+1)'(RECIP);
	assign bsp_full = (PAGE_W+5)'(quot_q) * (PAGE_W+5)'(PAGES_PER_BLOCK);

	// new flags of an access
	always_comb begin
		acc_need = 1'b0;
		acc_nf = rf;
		case (cmd_q)
			CMD_READ: begin
				acc_need = !rf[FL_READ];
				acc_nf = rf;
				acc_nf[FL_READ] = 1'b1;
			end
			CMD_WRITE: begin
				acc_need = partial_q && rf[FL_DATA] && !rf[FL_READ];
				acc_nf = rf;
				acc_nf[FL_READ] = 1'b1;
				acc_nf[FL_DIRTY] = 1'b1;
				acc_nf[FL_DATA] = 1'b1;
			end
			CMD_LOAD: begin
				acc_nf = fval_q;
			end
			default: begin
				acc_nf = rf;
			end
		endcase
	end

	// sequencer datapath: ram access, result emission and advance condition
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = AW'(p);
		ram_wdata = rf;
		ram_re = 1'b0;
		ram_raddr = AW'(p);
		emit = 1'b0;
		go = 1'b1;
		e_op = OP_ACK;
		e_page = page_q;
		e_flags = '0;
		e_last = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_DEC: begin
				if (bad_req) begin
					go = can_emit;
					emit = can_emit;
					e_op = (cmd_q > CMD_QUERY) ? OP_ACK : OP_RANGE;
					e_last = 1'b1;
				end else if (cmd_q != CMD_COMMIT) begin
					ram_re = 1'b1;
					ram_raddr = AW'(page_q);
				end
			end
			ST_ACC: begin
				go = !acc_need || can_emit;
				emit = acc_need && can_emit;
				e_op = OP_READ;
				ram_we = go;
				ram_waddr = AW'(page_q);
				ram_wdata = acc_nf;
			end
			ST_ACK: begin
				go = can_emit;
				emit = can_emit;
				e_page = ack_page_q;
				e_flags = ack_flags_q;
				e_last = 1'b1;
			end
			ST_RD: begin
				ram_re = !p_end;
			end
			ST_EX: begin
				e_page = p[PAGE_W-1:0];
				case (pass_q)
					PS_FETCH: begin
						go = !(rf[FL_DATA] && !rf[FL_READ]) || can_emit;
						emit = rf[FL_DATA] && !rf[FL_READ] && can_emit;
						e_op = OP_READ;
						ram_we = go;
						ram_wdata = rf;
						ram_wdata[FL_READ] = rf[FL_READ] || rf[FL_DATA];
						ram_wdata[FL_ERASE] = 1'b0;
					end
					PS_PROG: begin
						if (rf[FL_DIRTY] || (any_erase_q && rf[FL_DATA])) begin
							go = can_emit;
							emit = can_emit;
							ram_we = can_emit;
						end
						e_op = OP_PROGRAM;
						e_last = (idx_q == (any_erase_q ? last_dd_q : last_d_q));
						ram_wdata = rf;
						ram_wdata[FL_DIRTY] = 1'b0;
						ram_wdata[FL_ERASE] = 1'b1;
					end
					default: begin
						go = 1'b1;
					end
				endcase
			end
			ST_ERA: begin
				go = can_emit;
				emit = can_emit;
				e_op = OP_ERASE;
				e_page = bsp_q[PAGE_W-1:0];
			end
			default: begin
				go = 1'b1;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_pages_q <= MEM_PAGES_RST;
		end else if (cfg_we) begin
			mem_pages_q <= cfg_wdata;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			pass_q <= PS_SCAN;
			clr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(TOTAL_PAGES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (bad_req) begin
						if (go) begin
							state_q <= ST_IDLE;
						end
					end else if (cmd_q == CMD_COMMIT) begin
						state_q <= ST_BLK;
					end else begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (go) begin
						state_q <= ST_ACK;
					end
				end
				ST_ACK: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				ST_BLK: begin
					pass_q <= PS_SCAN;
					state_q <= ST_RD;
				end
				ST_RD: begin
					if (p_end) begin
						case (pass_q)
							PS_SCAN: begin
								if (!any_dirty_q) begin
									state_q <= ST_ACK;
								end else begin
									pass_q <= any_erase_q ? PS_FETCH : PS_PROG;
								end
							end
							PS_FETCH: begin
								state_q <= ST_ERA;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end else begin
						state_q <= ST_EX;
					end
				end
				ST_EX: begin
					if (go) begin
						state_q <= ST_RD;
					end
				end
				ST_ERA: begin
					if (go) begin
						pass_q <= PS_PROG;
						state_q <= ST_RD;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request capture and block walk registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q <= s_tuser;
				page_q <= s_tdata[PAGE_W-1:0];
				partial_q <= s_tdata[PAGE_W];
				fval_q <= s_tdata[PAGE_W+FLAG_W:PAGE_W+1];
			end
			ST_DEC: begin
				quot_q <= qprod[PAGE_W+RSH-1:RSH];
			end
			ST_ACC: begin
				ack_page_q <= page_q;
				ack_flags_q <= acc_nf;
			end
			ST_BLK: begin
				bsp_q <= bsp_full[MEMP_W-1:0];
				idx_q <= '0;
				any_dirty_q <= 1'b0;
				any_erase_q <= 1'b0;
			end
			ST_RD: begin
				if (p_end) begin
					idx_q <= '0;
					ack_page_q <= bsp_q[PAGE_W-1:0];
					ack_flags_q <= pflags_q;
				end
			end
			ST_EX: begin
				if (go) begin
					idx_q <= idx_q + IW'(1);
				end
				if (pass_q == PS_SCAN) begin
					if (rf[FL_DIRTY]) begin
						any_dirty_q <= 1'b1;
						last_d_q <= idx_q;
						if (rf[FL_ERASE]) begin
							any_erase_q <= 1'b1;
						end
					end
					if (rf[FL_DIRTY] || rf[FL_DATA]) begin
						last_dd_q <= idx_q;
					end
					if (p == {1'b0, page_q}) begin
						pflags_q <= rf;
					end
				end
			end
			ST_ERA: begin
				idx_q <= '0;
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			op_q <= e_op;
			fpage_q <= e_page;
			oflags_q <= e_flags;
			olast_q <= e_last;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {oflags_q, fpage_q};
	assign m_tuser = op_q;
	assign m_tlast = olast_q;

endmodule

// File: design/fpsw_ram.sv
// generic simple dual-port ram with registered read
module fpsw_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, holds when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/fpsw_checker.sv
// port-level checker for the flash page state write-back unit, with its bind
module fpsw_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [fpsw_pkg::M_TDATA_W-1:0]   m_tdata,
	input logic [fpsw_pkg::OP_W-1:0]        m_tuser,
	input logic                             m_tlast
);

	import fpsw_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// only known operations leave the block
	a_op: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= OP_RANGE)
		else $error("unknown operation code");

	// flags travel only on acknowledges
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != OP_ACK |-> m_tdata[15:12] == '0)
		else $error("flags on a flash operation");

	// a range error ends its request
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == OP_RANGE |-> m_tlast)
		else $error("range error not last");

	// an erase or a page read never ends its request
	a_erase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == OP_ERASE || m_tuser == OP_READ) |-> !m_tlast)
		else $error("erase or page read marked last");

endmodule

bind flash_page_state_write_back_unit fpsw_checker u_fpsw_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);
